>>> design/rrts_pkg.sv
// Shared types and constants for the round-robin time-slice scheduler core.
// Used by rrts_ctrl, rrts_dpath and the top level; depends on nothing.
package rrts_pkg;

   localparam int MAX_PROCS   = 16;
   localparam int SLOT_W      = $clog2(MAX_PROCS);
   localparam int NPROC_W     = $clog2(MAX_PROCS + 1);
   localparam int WORK_W      = 16;
   localparam int ARRIVAL_W   = 16;
   localparam int TIME_W      = 24;
   localparam int PCOUNT_W    = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 72;

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUANTUM    = 1'b0,
      CSR_PROC_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE_SCAN,
      ST_POP,
      ST_EXEC,
      ST_POST_SCAN,
      ST_REQUEUE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic scan;
      logic mark_idle;
      logic pop;
      logic exec;
      logic requeue;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic all_done;
      logic fifo_empty;
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rrts_dpath.sv
// Datapath: process table, remaining-work and ready-queue RAMs, slot flags,
// time, config registers and the result register. Depends on rrts_pkg, rrts_ram.
module rrts_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [rrts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [rrts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rrts_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  rrts_pkg::dp_cmd_type                 cmd,
   output rrts_pkg::dp_status_type              status
);
   import rrts_pkg::*;

   logic [WORK_W-1:0]     quantum_ff, quantum_in;
   logic [PCOUNT_W-1:0]   pcount_ff, pcount_in;
   logic [NPROC_W-1:0]    n_use;
   logic [WORK_W-1:0]     q_eff;

   logic [SLOT_W-1:0]     req_slot;
   logic [ARRIVAL_W-1:0]  req_arrival;
   logic [WORK_W-1:0]     req_burst;

   logic [SLOT_W-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [NPROC_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]     now_ff, now_in;

   logic [MAX_PROCS-1:0]  queued_ff, queued_in;
   logic [MAX_PROCS-1:0]  rem_valid_ff, rem_valid_in;
   logic [MAX_PROCS-1:0]  done_ff, done_in;
   logic [MAX_PROCS-1:0]  burst_zero_ff, burst_zero_in;
   logic [MAX_PROCS-1:0]  zero_work, in_use;

   logic [NPROC_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                  scan_issue, chk_hit;

   logic [SLOT_W-1:0]     served_ff, served_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [WORK_W-1:0]     run_ff, run_in;
   logic                  fin_ff, fin_in;
   logic [TIME_W-1:0]     comp_ff, comp_in;
   logic                  idle_ff, idle_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                  push;
   logic [SLOT_W-1:0]     push_slot;
   logic [SLOT_W-1:0]     fifo_rd;
   logic [SLOT_W-1:0]     tbl_addr;
   logic [ARRIVAL_W+WORK_W-1:0] tbl_rd;
   logic [ARRIVAL_W-1:0]  arrival_rd;
   logic [WORK_W-1:0]     burst_rd, rem_rd, eff_work, rem_new, run_new;
   logic                  over_quantum;
   logic [TIME_W-1:0]     now_sum;
   logic                  all_done;

   assign req_slot    = req_tdata[SLOT_W-1:0];
   assign req_arrival = req_tdata[SLOT_W +: ARRIVAL_W];
   assign req_burst   = req_tdata[SLOT_W+ARRIVAL_W +: WORK_W];

   // Clamp the slot count into 1..MAX_PROCS, treat a zero quantum as one.
   always_comb begin
      priority if (pcount_ff == '0) begin
         n_use = NPROC_W'(1);
      end else if (int'(pcount_ff) > MAX_PROCS) begin
         n_use = NPROC_W'(MAX_PROCS);
      end else begin
         n_use = NPROC_W'(pcount_ff);
      end
   end

   assign q_eff = (quantum_ff == '0) ? WORK_W'(1) : quantum_ff;

   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         in_use[i] = (i < int'(n_use));
      end
   end

   assign zero_work = burst_zero_ff | done_ff;
   assign all_done  = &(zero_work | ~in_use);

   // Process table {burst, arrival}
   assign tbl_addr = cmd.pop ? fifo_rd : scan_idx_ff[SLOT_W-1:0];

   rrts_ram #(.WIDTH(ARRIVAL_W + WORK_W), .DEPTH(MAX_PROCS)) u_table_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (req_slot),
      .wr_data ({req_burst, req_arrival}),
      .rd_addr (tbl_addr),
      .rd_data (tbl_rd)
   );

   rrts_ram #(.WIDTH(WORK_W), .DEPTH(MAX_PROCS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (cmd.exec),
      .wr_addr (served_ff),
      .wr_data (rem_new),
      .rd_addr (tbl_addr),
      .rd_data (rem_rd)
   );

   rrts_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PROCS)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (push_slot),
      .rd_addr (head_ff),
      .rd_data (fifo_rd)
   );

   assign arrival_rd = tbl_rd[ARRIVAL_W-1:0];
   assign burst_rd   = tbl_rd[ARRIVAL_W +: WORK_W];

   // Admission scan: issue one slot read per cycle, check it in the cycle after.
   assign scan_issue = cmd.scan && (scan_idx_ff < n_use);
   assign chk_hit    = cmd.scan && chk_valid_ff
                       && ({{(TIME_W-ARRIVAL_W){1'b0}}, arrival_rd} <= now_ff)
                       && !queued_ff[chk_idx_ff] && !zero_work[chk_idx_ff];

   assign push      = (chk_hit || (cmd.requeue && !fin_ff)) && (int'(count_ff) < MAX_PROCS);
   assign push_slot = cmd.requeue ? served_ff : chk_idx_ff;

   // Slice execution
   assign eff_work     = rem_valid_ff[served_ff] ? rem_rd : burst_rd;
   assign over_quantum = eff_work > q_eff;
   assign run_new      = over_quantum ? q_eff : eff_work;
   assign rem_new      = over_quantum ? (eff_work - q_eff) : '0;
   assign now_sum      = now_ff + {{(TIME_W-WORK_W){1'b0}}, run_new};

   always_comb begin
      quantum_in    = quantum_ff;
      pcount_in     = pcount_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      queued_in     = queued_ff;
      rem_valid_in  = rem_valid_ff;
      done_in       = done_ff;
      burst_zero_in = burst_zero_ff;
      scan_idx_in   = '0;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      served_in     = served_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      fin_in        = fin_ff;
      comp_in       = comp_ff;
      idle_in       = idle_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUANTUM:    quantum_in = csr_wdata[WORK_W-1:0];
            CSR_PROC_COUNT: pcount_in  = csr_wdata[PCOUNT_W-1:0];
         endcase
      end

      // Load restarts the schedule; remaining work falls back to the burst.
      if (cmd.load) begin
         burst_zero_in[req_slot] = (req_burst == '0);
         queued_in    = '0;
         rem_valid_in = '0;
         done_in      = '0;
         head_in      = '0;
         tail_in      = '0;
         count_in     = '0;
         now_in       = '0;
      end

      if (cmd.step) begin
         start_in  = now_ff;
         served_in = '0;
         run_in    = '0;
         fin_in    = 1'b0;
         comp_in   = '0;
         idle_in   = 1'b0;
      end

      if (scan_issue) begin
         scan_idx_in  = scan_idx_ff + NPROC_W'(1);
         chk_valid_in = 1'b1;
         chk_idx_in   = scan_idx_ff[SLOT_W-1:0];
      end else if (cmd.scan) begin
         scan_idx_in  = scan_idx_ff;
      end

      if (chk_hit) begin
         queued_in[chk_idx_ff] = 1'b1;
      end

      if (push) begin
         tail_in  = (int'(tail_ff) == MAX_PROCS - 1) ? '0 : tail_ff + SLOT_W'(1);
         count_in = count_ff + NPROC_W'(1);
      end

      if (cmd.mark_idle) begin
         idle_in = 1'b1;
         now_in  = now_ff + TIME_W'(1);
      end

      if (cmd.pop) begin
         served_in = fifo_rd;
         head_in   = (int'(head_ff) == MAX_PROCS - 1) ? '0 : head_ff + SLOT_W'(1);
         count_in  = count_ff - NPROC_W'(1);
      end

      if (cmd.exec) begin
         rem_valid_in[served_ff] = 1'b1;
         if (!over_quantum) begin
            done_in[served_ff] = 1'b1;
         end
         run_in  = run_new;
         fin_in  = !over_quantum;
         comp_in = over_quantum ? '0 : now_sum;
         now_in  = now_sum;
      end

      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, all_done, idle_ff, comp_ff, fin_ff, run_ff, start_ff,
                          served_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff    <= WORK_W'(2);
         pcount_ff     <= PCOUNT_W'(1);
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         now_ff        <= '0;
         queued_ff     <= '0;
         rem_valid_ff  <= '0;
         done_ff       <= '0;
         scan_idx_ff   <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         quantum_ff    <= quantum_in;
         pcount_ff     <= pcount_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         now_ff        <= now_in;
         queued_ff     <= queued_in;
         rem_valid_ff  <= rem_valid_in;
         done_ff       <= done_in;
         scan_idx_ff   <= scan_idx_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_zero_ff <= burst_zero_in;
      chk_idx_ff    <= chk_idx_in;
      served_ff     <= served_in;
      start_ff      <= start_in;
      run_ff        <= run_in;
      fin_ff        <= fin_in;
      comp_ff       <= comp_in;
      idle_ff       <= idle_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid        = rsp_tvalid_ff;
   assign rsp_tdata         = rsp_tdata_ff;
   assign status.all_done   = all_done;
   assign status.fifo_empty = (count_ff == '0);
   assign status.scan_done  = (scan_idx_ff >= n_use) && !chk_valid_ff;
   assign status.out_free   = !rsp_tvalid_ff || rsp_tready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_PROCS)
      else $error("ready queue count above capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from empty ready queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      int'(tail_ff) == (int'(head_ff) + int'(count_ff)) % MAX_PROCS)
      else $error("queue pointers disagree with count");

   a_marks_cover: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) >= int'(count_ff))
      else $error("more queued entries than marked slots");

endmodule

>>> design/rrts_ctrl.sv
// Controller state machine: sequences load, admission scans, pop, slice
// execution, requeue and result hand-off. Depends on rrts_pkg.
module rrts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tuser,
   output logic                    req_tready,
   input  rrts_pkg::dp_status_type status,
   output rrts_pkg::dp_cmd_type    cmd
);
   import rrts_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (command_type'(req_tuser) == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.step = 1'b1;
                  priority if (status.all_done) begin
                     state_in = ST_EMIT;
                  end else if (status.fifo_empty) begin
                     state_in = ST_PRE_SCAN;
                  end else begin
                     state_in = ST_POP;
                  end
               end
            end
         end
         ST_PRE_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               if (status.fifo_empty) begin
                  cmd.mark_idle = 1'b1;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_POST_SCAN;
         end
         ST_POST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_REQUEUE;
            end
         end
         ST_REQUEUE: begin
            cmd.requeue = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the result register can take the transaction
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/round_robin_time_slice_scheduler_core.sv
// Round-robin time-slice scheduler core: controller plus datapath.
// Load: no result. Step with all slots done: straight to the result after accept.
// Step with a queued slot: pop, slice execution, one-slot-per-cycle admission
// scan over the table RAM, requeue, result; an empty queue adds a second scan
// first (idle step: scan, then result). Next request accepted the cycle after.
// Synchronous active-high reset: empty queue, time 0, quantum 2, process count 1.
module round_robin_time_slice_scheduler_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, low bit up: slot[3:0], arrival[19:4], burst[35:20], zero pad
   input  logic [rrts_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: command (0 load, 1 step)
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata, low bit up: served_slot[3:0], start_time[27:4], run_length[43:28],
   // finished[44], completion_time[68:45], idle[69], all_done[70], zero pad
   output logic [rrts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [rrts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rrts_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rrts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrts_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> tb/round_robin_time_slice_scheduler_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for round_robin_time_slice_scheduler_core: load and step commands go
// in on the request stream, and each slice report is checked against an in-bench scheduler.
// Depends on rrts_pkg and the core.
module round_robin_time_slice_scheduler_core_tb;
   import rrts_pkg::*;

   localparam int WATCHDOG_LIMIT    = 3000;
   localparam int DRAIN_CYCLES      = 2 * MAX_PROCS + 20;
   localparam int PHASE_ITEMS       = 110;
   localparam int MAX_STEPS_PER_SET = 60;
   localparam int REPORT_LIMIT      = 10;

   typedef struct {
      command_type          cmd;
      logic [SLOT_W-1:0]    slot;
      logic [ARRIVAL_W-1:0] arrival;
      logic [WORK_W-1:0]    burst;
   } sched_command_type;

   typedef struct {
      logic [SLOT_W-1:0] served_slot;
      logic [TIME_W-1:0] start_time;
      logic [WORK_W-1:0] run_length;
      logic              finished;
      logic [TIME_W-1:0] completion_time;
      logic              idle;
      logic              all_done;
   } slice_report_type;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_pattern_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_W-1:0]       req_tdata  = '0;
   logic                        req_tuser  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]       rsp_tdata;
   logic                        csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index  = CSR_QUANTUM;
   logic [CSR_DATA_W-1:0]       csr_wdata  = '0;

   // scheduler state as the bench sees it
   logic [ARRIVAL_W-1:0] model_arrival [MAX_PROCS];
   logic [WORK_W-1:0]    model_burst   [MAX_PROCS];
   logic [WORK_W-1:0]    model_left    [MAX_PROCS];
   logic                 model_queued  [MAX_PROCS];
   logic [SLOT_W-1:0]    model_ready   [$];
   logic [TIME_W-1:0]    model_now     = '0;
   logic [WORK_W-1:0]    model_quantum = 16'd2;
   logic [PCOUNT_W-1:0]  model_pcount  = 5'd1;

   sched_command_type  pending_commands [$];
   slice_report_type   expected_slices  [$];
   sched_command_type  cmd_on_bus;
   slice_report_type   seen_slice;

   // what the stimulus generator has loaded, used to size step runs
   int                 gen_arrival [MAX_PROCS];
   int                 gen_burst   [MAX_PROCS];
   int                 issued_items = 0;
   int                 fault_count  = 0;
   int                 quiet_cycles = 0;
   int                 burst_left   = 0;
   int                 gap_left     = 0;
   int                 pattern_left = 0;
   ready_pattern_type  ready_mode   = READY_ALWAYS;

   round_robin_time_slice_scheduler_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int slots_in_use();
      if (model_pcount == 0) return 1;
      if (model_pcount > MAX_PROCS) return MAX_PROCS;
      return int'(model_pcount);
   endfunction

   function automatic bit schedule_complete();
      for (int i = 0; i < slots_in_use(); i++)
         if (model_left[i] != 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void admit_arrivals();
      for (int i = 0; i < slots_in_use(); i++) begin
         if (TIME_W'(model_arrival[i]) <= model_now && !model_queued[i] && model_left[i] != 0) begin
            model_ready.push_back(SLOT_W'(i));
            model_queued[i] = 1'b1;
         end
      end
   endfunction

   function automatic void restart_schedule();
      for (int i = 0; i < MAX_PROCS; i++) begin
         model_left[i]   = model_burst[i];
         model_queued[i] = 1'b0;
      end
      model_ready.delete();
      model_now = '0;
   endfunction

   // Apply one accepted command; a step leaves one expected slice report.
   function automatic void predict_slice(sched_command_type c);
      slice_report_type  rpt;
      logic [WORK_W-1:0] q;
      logic [SLOT_W-1:0] s;
      if (c.cmd == CMD_LOAD) begin
         model_arrival[c.slot] = c.arrival;
         model_burst[c.slot]   = c.burst;
         restart_schedule();
         return;
      end
      rpt = '{default: '0};
      rpt.start_time = model_now;
      if (!schedule_complete()) begin
         if (model_ready.size() == 0) admit_arrivals();
         if (model_ready.size() == 0) begin
            rpt.idle  = 1'b1;
            model_now = model_now + 1'b1;
         end else begin
            q = (model_quantum == 0) ? WORK_W'(1) : model_quantum;
            s = model_ready.pop_front();
            rpt.served_slot = s;
            if (model_left[s] > q) begin
               rpt.run_length = q;
               model_left[s]  = model_left[s] - q;
               model_now      = model_now + TIME_W'(q);
            end else begin
               rpt.run_length      = model_left[s];
               model_now           = model_now + TIME_W'(model_left[s]);
               model_left[s]       = '0;
               rpt.finished        = 1'b1;
               rpt.completion_time = model_now;
            end
            admit_arrivals();
            if (model_left[s] != 0) model_ready.push_back(s);
         end
      end
      rpt.all_done = schedule_complete();
      expected_slices.push_back(rpt);
   endfunction

   function automatic void check_slice(slice_report_type got);
      slice_report_type want;
      if (expected_slices.size() == 0) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("%0t: slice report with none pending: slot %0d start %0d run %0d",
                     $time, got.served_slot, got.start_time, got.run_length);
         return;
      end
      want = expected_slices.pop_front();
      if (got.served_slot !== want.served_slot || got.start_time !== want.start_time ||
          got.run_length !== want.run_length || got.finished !== want.finished ||
          got.completion_time !== want.completion_time || got.idle !== want.idle ||
          got.all_done !== want.all_done) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: slice mismatch, expected slot %0d start %0d run %0d fin %0b comp %0d",
                     $time, want.served_slot, want.start_time, want.run_length,
                     want.finished, want.completion_time);
            $display("   idle %0b done %0b; got slot %0d start %0d run %0d fin %0b comp %0d",
                     want.idle, want.all_done, got.served_slot, got.start_time,
                     got.run_length, got.finished, got.completion_time);
            $display("   idle %0b done %0b", got.idle, got.all_done);
         end
      end
   endfunction

   // request driver: bursts of transactions with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_slice(cmd_on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_commands.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               cmd_on_bus = pending_commands.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_on_bus.cmd;
               req_tdata  <= REQ_DATA_W'({cmd_on_bus.burst, cmd_on_bus.arrival, cmd_on_bus.slot});
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
   end

   // response back-pressure: switch between ready patterns every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            ready_mode   = ready_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 160);
         end else begin
            pattern_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
            default:      rsp_tready <= pattern_left[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_slice.served_slot     = rsp_tdata[3:0];
         seen_slice.start_time      = rsp_tdata[27:4];
         seen_slice.run_length      = rsp_tdata[43:28];
         seen_slice.finished        = rsp_tdata[44];
         seen_slice.completion_time = rsp_tdata[68:45];
         seen_slice.idle            = rsp_tdata[69];
         seen_slice.all_done        = rsp_tdata[70];
         check_slice(seen_slice);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("round_robin_time_slice_scheduler_core verification failed");
      $finish;
   end

   function automatic int pick_arrival();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 12);
      if (r < 95) return $urandom_range(0, 80);
      return $urandom_range(0, 65535);
   endfunction

   function automatic int pick_burst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 10);
      if (r < 95) return $urandom_range(1, 40);
      return $urandom_range(1, 65535);
   endfunction

   function automatic void queue_load(int slot, int arrival, int burst);
      sched_command_type c;
      c.cmd     = CMD_LOAD;
      c.slot    = SLOT_W'(slot);
      c.arrival = ARRIVAL_W'(arrival);
      c.burst   = WORK_W'(burst);
      pending_commands.push_back(c);
      gen_arrival[slot] = arrival;
      gen_burst[slot]   = burst;
      issued_items++;
   endfunction

   function automatic void queue_steps(int count);
      sched_command_type c;
      repeat (count) begin
         // payload of a step is ignored, so fill it with noise
         c.cmd     = CMD_STEP;
         c.slot    = SLOT_W'($urandom);
         c.arrival = ARRIVAL_W'($urandom);
         c.burst   = WORK_W'($urandom);
         pending_commands.push_back(c);
         issued_items++;
      end
   endfunction

   // Steps needed to run the loaded table to completion, roughly.
   function automatic int estimate_steps();
      int q;
      int total;
      int latest;
      q      = (model_quantum == 0) ? 1 : int'(model_quantum);
      total  = 0;
      latest = 0;
      for (int i = 0; i < slots_in_use(); i++) begin
         total += (gen_burst[i] + q - 1) / q;
         if (gen_arrival[i] > latest) latest = gen_arrival[i];
      end
      return total + latest + 2;
   endfunction

   function automatic void queue_job_set();
      int n_steps;
      int split;
      // pull back slots left with far arrivals or huge bursts
      for (int i = 0; i < MAX_PROCS; i++)
         if (gen_arrival[i] > 100 || gen_burst[i] > 500)
            queue_load(i, $urandom_range(0, 12), $urandom_range(1, 10));
      repeat ($urandom_range(1, 4))
         queue_load($urandom_range(0, MAX_PROCS - 1), pick_arrival(), pick_burst());
      n_steps = estimate_steps() + $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) n_steps = $urandom_range(0, n_steps / 2);
      if (n_steps > MAX_STEPS_PER_SET) n_steps = MAX_STEPS_PER_SET;
      // restart some schedules mid-run with a load
      if (n_steps > 2 && $urandom_range(0, 4) == 0) begin
         split = $urandom_range(1, n_steps - 1);
         queue_steps(split);
         queue_load($urandom_range(0, MAX_PROCS - 1), pick_arrival(), pick_burst());
         n_steps -= split;
      end
      queue_steps(n_steps);
   endfunction

   task automatic write_csr(csr_index_type index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_QUANTUM)
         model_quantum = value;
      else
         model_pcount = value[PCOUNT_W-1:0];
   endtask

   // Hold until every command is in and every report is out, then let the core go quiet.
   task automatic settle();
      do
         @(negedge clock);
      while (pending_commands.size() != 0 || req_tvalid || expected_slices.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int quantum_value, int count_value);
      int                    phase_start;
      logic [CSR_DATA_W-1:0] count_word;
      count_word                 = CSR_DATA_W'($urandom);
      count_word[PCOUNT_W-1:0]   = PCOUNT_W'(count_value);
      write_csr(CSR_QUANTUM, CSR_DATA_W'(quantum_value));
      write_csr(CSR_PROC_COUNT, count_word);
      phase_start = issued_items;
      while (issued_items - phase_start < PHASE_ITEMS) queue_job_set();
      settle();
   endtask

   initial begin
      restart_schedule();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table, then run slot 0 at reset settings: idle twice, two slices,
      // then all done
      queue_load(0, 2, 3);
      queue_load(1, 0, 1);
      for (int i = 2; i < MAX_PROCS; i++) queue_load(i, i % 5, i + 1);
      queue_steps(5);
      settle();

      // full-width arrival, burst and quantum
      write_csr(CSR_QUANTUM, 16'hFFFF);
      write_csr(CSR_PROC_COUNT, CSR_DATA_W'(2));
      queue_load(0, 0, 65535);
      queue_load(1, 65535, 1);
      queue_steps(3);
      settle();

      run_phase(1, 4);
      run_phase(0, 3);
      run_phase(3, MAX_PROCS);
      run_phase(65535, 8);
      run_phase(2, 0);
      run_phase(4, MAX_PROCS + 1);
      run_phase(5, 31);
      repeat (2) run_phase($urandom_range(1, 8), $urandom_range(1, MAX_PROCS));

      if (fault_count == 0 && expected_slices.size() == 0)
         $display("round_robin_time_slice_scheduler_core verification clean");
      else
         $display("round_robin_time_slice_scheduler_core verification failed");
      $finish;
   end

endmodule
